>>> rtl/core/rcpw_pkg.sv
// shared types and constants of the rc pulse width reader
package rcpw_pkg;

  localparam int VALUE_W            = 16;
  localparam int TIME_W             = 32;
  localparam int HISTORY_DEPTH_DEF  = 4;
  localparam int CFG_IDX_W          = 2;

  localparam logic [VALUE_W-1:0] VALUE_MAX          = '1;
  localparam logic [VALUE_W-1:0] MIN_WIDTH_RESET    = 16'd1000;
  localparam logic [VALUE_W-1:0] MAX_WIDTH_RESET    = 16'd2000;
  localparam logic [VALUE_W-1:0] DEFAULT_VAL_RESET  = 16'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_VAL = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_DIVIDE,
    ST_SCAN,
    ST_OUTPUT
  } rcpw_state_t;

  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] diff;
    logic [VALUE_W-1:0] den;
  } rcpw_div_req_t;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] quotient;
  } rcpw_div_rsp_t;

endpackage

>>> rtl/core/rcpw_div.sv
// bit-serial restoring divider: floor(65535 * diff / den), needs diff < den
module rcpw_div (
  input  logic                   clk,
  input  logic                   rst,
  input  rcpw_pkg::rcpw_div_req_t req,
  output rcpw_pkg::rcpw_div_rsp_t rsp
);
  import rcpw_pkg::*;

  localparam int CNT_W = $clog2(VALUE_W);

  logic [VALUE_W-1:0]   rem;
  logic [VALUE_W-1:0]   quo;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic                 done;
  logic [2*VALUE_W-1:0] num;
  logic [VALUE_W:0]     trial;
  logic                 fits;

  // 65535 * diff as (diff << 16) - diff
  assign num   = {req.diff, {VALUE_W{1'b0}}} - {{VALUE_W{1'b0}}, req.diff};
  assign trial = {rem, quo[VALUE_W-1]};
  assign fits  = trial >= {1'b0, req.den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_W'(VALUE_W - 1));
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == CNT_W'(VALUE_W - 1))) begin
        busy <= 1'b0;
      end
    end
  end

  // high half of the dividend is already below den, so one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= num[2*VALUE_W-1:VALUE_W];
      quo <= num[VALUE_W-1:0];
      cnt <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= VALUE_W'(trial - {1'b0, req.den});
      end else begin
        rem <= trial[VALUE_W-1:0];
      end
      quo <= {quo[VALUE_W-2:0], fits};
      cnt <= cnt + CNT_W'(1);
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

>>> rtl/core/rc_pulse_width_reader.sv
// top level of the rc pulse width reader
//
// Input beats carry a pin level sample, its microsecond timestamp and a
// reinit flag; every accepted beat gives exactly one output beat.
// A rising edge stores the timestamp. A falling edge measures the width,
// clamps and scales it to 0..65535 between min_width_us and max_width_us,
// pushes it into the history and reports the minimum of the newest
// HISTORY_DEPTH-1 entries.
// Sequence: a beat with no falling edge is answered in the next cycle and
// the next beat may follow at once unless out_stall holds the output. A
// falling edge goes through these steps: capture the width, clamp, the
// bit-serial divider (one quotient bit a cycle), the minimum scan over the
// history (one entry a cycle) and the load of the output register.
// Clamped widths skip the divider.
// While the output register holds an untaken beat and out_stall is high,
// in_stall stays high, so a stalled receiver holds back the sender.
// Reset loads the register defaults, clears the level state and fills the
// history with zeros. Configuration beats are always taken (cfg_ready high).
module rc_pulse_width_reader #(
  parameter int HISTORY_DEPTH = rcpw_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            pin_level,
  input  logic [rcpw_pkg::TIME_W-1:0]     time_us,
  input  logic                            reinit,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rcpw_pkg::VALUE_W-1:0]    current_value,
  output logic                            new_measurement,
  output logic [rcpw_pkg::VALUE_W-1:0]    latest_value,
  output logic [rcpw_pkg::TIME_W-1:0]     last_width_us,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rcpw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcpw_pkg::VALUE_W-1:0]    cfg_data
);
  import rcpw_pkg::*;

  localparam int IDX_W = $clog2(HISTORY_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);

  rcpw_state_t        state;
  rcpw_state_t        state_next;

  logic [VALUE_W-1:0] min_width_us;
  logic [VALUE_W-1:0] max_width_us;
  logic [VALUE_W-1:0] fill_value;

  logic               level_was_high;
  logic [TIME_W-1:0]  rise_time;
  logic [TIME_W-1:0]  measured_width;
  logic [VALUE_W-1:0] hist [HISTORY_DEPTH];
  logic [VALUE_W-1:0] hist_min;
  logic [IDX_W-1:0]   scan_idx;

  logic               in_acc;
  logic               fall;
  logic               out_free;
  logic               sat_hi;
  logic               sat_lo;
  logic               push_en;
  logic [VALUE_W-1:0] push_val;
  logic               load_direct;
  logic               load_edge;

  rcpw_div_req_t      div_req;
  rcpw_div_rsp_t      div_rsp;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign fall      = !reinit && !pin_level && level_was_high;
  assign out_free  = !out_valid || !out_stall;
  assign sat_hi    = measured_width >= TIME_W'(max_width_us);
  assign sat_lo    = measured_width <= TIME_W'(min_width_us);

  rcpw_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && fall) state_next = ST_SCALE;
      end
      ST_SCALE: begin
        state_next = (sat_hi || sat_lo) ? ST_SCAN : ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_rsp.done) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_idx == LAST_IDX) state_next = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall      = 1'b1;
    push_en       = 1'b0;
    push_val      = '0;
    load_direct   = 1'b0;
    load_edge     = 1'b0;
    div_req.start = 1'b0;
    div_req.diff  = measured_width[VALUE_W-1:0] - min_width_us;
    div_req.den   = max_width_us - min_width_us;
    unique case (state)
      ST_IDLE: begin
        in_stall    = !out_free;
        load_direct = in_acc && !fall;
      end
      ST_SCALE: begin
        push_en       = sat_hi || sat_lo;
        push_val      = sat_hi ? VALUE_MAX : '0;
        div_req.start = !(sat_hi || sat_lo);
      end
      ST_DIVIDE: begin
        push_en  = div_rsp.done;
        push_val = div_rsp.quotient;
      end
      ST_SCAN: begin
      end
      ST_OUTPUT: begin
        load_edge = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      min_width_us   <= MIN_WIDTH_RESET;
      max_width_us   <= MAX_WIDTH_RESET;
      fill_value     <= DEFAULT_VAL_RESET;
      level_was_high <= 1'b0;
      rise_time      <= '0;
      measured_width <= '0;
      hist_min       <= '0;
      out_valid      <= 1'b0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist[i] <= '0;
      end
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MIN_WIDTH:   min_width_us <= cfg_data;
          CFG_MAX_WIDTH:   max_width_us <= cfg_data;
          CFG_DEFAULT_VAL: fill_value   <= cfg_data;
          default: begin
          end
        endcase
      end

      if (in_acc) begin
        if (reinit) begin
          level_was_high <= 1'b0;
          rise_time      <= '0;
          measured_width <= '0;
          hist_min       <= fill_value;
          for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist[i] <= fill_value;
          end
        end else if (pin_level) begin
          if (!level_was_high) begin
            rise_time      <= time_us;
            level_was_high <= 1'b1;
          end
        end else if (level_was_high) begin
          measured_width <= time_us - rise_time;
          level_was_high <= 1'b0;
        end
      end

      // shift line, oldest entry at index 0
      if (push_en) begin
        for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
          hist[i] <= hist[i+1];
        end
        hist[HISTORY_DEPTH-1] <= push_val;
        hist_min              <= VALUE_MAX;
      end else if (state == ST_SCAN) begin
        if (hist[scan_idx] < hist_min) hist_min <= hist[scan_idx];
      end

      if (load_direct || load_edge) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // scan index and output beat registers
  always_ff @(posedge clk) begin
    if (push_en) begin
      scan_idx <= IDX_W'(1);
    end else if (state == ST_SCAN) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end

    if (load_direct) begin
      new_measurement <= 1'b0;
      if (reinit) begin
        current_value <= fill_value;
        latest_value  <= fill_value;
        last_width_us <= '0;
      end else begin
        current_value <= hist_min;
        latest_value  <= hist[HISTORY_DEPTH-1];
        last_width_us <= measured_width;
      end
    end else if (load_edge) begin
      new_measurement <= 1'b1;
      current_value   <= hist_min;
      latest_value    <= hist[HISTORY_DEPTH-1];
      last_width_us   <= measured_width;
    end
  end

  // newest entry is always part of the minimum
  a_min_le_latest: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> current_value <= latest_value)
    else $error("current_value above latest_value");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == ST_DIVIDE)
    else $error("divider finished outside the divide phase");

  a_fall_to_scale: assert property (@(posedge clk) disable iff (rst)
    (in_acc && fall) |=> (state == ST_SCALE && !out_valid) || state == ST_SCALE)
    else $error("falling edge did not start scaling");

  a_edge_beat_flag: assert property (@(posedge clk) disable iff (rst)
    load_edge |=> out_valid && new_measurement)
    else $error("edge beat lost its measurement flag");

endmodule
